### design/mtr_pkg.sv
// Shared types and constants for the markdown terminal renderer.
package mtr_pkg;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_TICK  = 8'h60;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [7:0] WRAP_RESET = 8'd79;

	localparam int NSEG = 10;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_HEAD  = 2'd1,
		MODE_CODE  = 2'd2
	} mode_t;

	// Output segments, in the order they are emitted within one transaction.
	typedef enum logic [3:0] {
		SEG_HEND     = 4'd0,
		SEG_BOLD_ON  = 4'd1,
		SEG_HSPACE   = 4'd2,
		SEG_INDENT   = 4'd3,
		SEG_WRAP     = 4'd4,
		SEG_SPACE    = 4'd5,
		SEG_CHAR     = 4'd6,
		SEG_DBLNL    = 4'd7,
		SEG_BOLD_OFF = 4'd8,
		SEG_RESET    = 4'd9
	} seg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic cfg_we;
	} ctl_cmd_t;

	typedef struct packed {
		logic plan_any;
		logic last_byte;
	} dp_status_t;

endpackage

### design/mtr_ctrl.sv
// Controller state machine for the markdown terminal renderer.
module mtr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  mtr_pkg::dp_status_t  status,
	output mtr_pkg::ctl_cmd_t    cmd
);
	import mtr_pkg::*;

	ctl_state_t state_q, state_d;
	logic       out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.plan_any) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.step && status.last_byte) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_EMIT: begin
				cmd.step = !out_valid_q || out_ready;
			end
			default: ;
		endcase
		cfg_ready  = 1'b1;
		cmd.cfg_we = cfg_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/mtr_dpath.sv
// Datapath for the markdown terminal renderer: render state, plan decode, byte sequencer.
module mtr_dpath #(
	parameter int MAX_HEADING_LEVEL = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtr_pkg::in_item_t    in_data,
	input  logic [7:0]           cfg_data,
	input  mtr_pkg::ctl_cmd_t    cmd,
	output mtr_pkg::dp_status_t  status,
	output mtr_pkg::out_item_t   out_data
);
	import mtr_pkg::*;

	localparam int HL_W  = $clog2(MAX_HEADING_LEVEL + 1);
	localparam int IDX_W = (HL_W > 3) ? HL_W : 3;
	localparam logic [HL_W-1:0] HL_MAX = HL_W'(MAX_HEADING_LEVEL);
	localparam logic [HL_W-1:0] HL_ONE = HL_W'(1);

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [2:0] k);
		logic [8:0] s;
		s = {1'b0, a} + {6'd0, k};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	// render state
	mode_t           mode_q;
	logic [HL_W-1:0] hl_q;
	logic [7:0]      col_q;
	logic            als_q, nlp_q, inws_q;
	logic [7:0]      wrap_q;

	// plan
	logic [NSEG-1:0]  mask_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       ch_q;
	logic [7:0]       obyte_q;
	logic             olast_q;

	// decode results
	mode_t           n_mode;
	logic [HL_W-1:0] n_hl;
	logic [7:0]      n_col;
	logic            n_als, n_nlp, n_inws;
	logic [NSEG-1:0] p_mask;
	logic [7:0]      p_ch;

	always_comb begin
		logic       do_plain, do_para, collapse, is_sp;
		logic [7:0] c, up;
		c        = in_data.text_byte;
		up       = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_OFS : c;
		is_sp    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
		do_plain = 1'b0;
		do_para  = 1'b0;
		collapse = 1'b1;
		n_mode   = mode_q;
		n_hl     = hl_q;
		n_col    = col_q;
		n_als    = als_q;
		n_nlp    = nlp_q;
		n_inws   = inws_q;
		p_mask   = '0;
		p_ch     = c;

		if (in_data.end_of_text) begin
			p_mask[SEG_RESET] = 1'b1;
			n_mode = MODE_PLAIN;
			n_hl   = '0;
			n_col  = '0;
			n_als  = 1'b1;
			n_nlp  = 1'b0;
			n_inws = 1'b1;
		end else begin
			case (mode_q)
				MODE_HEAD: begin
					if (c == CH_HASH && als_q) begin
						if (hl_q < HL_MAX) n_hl = hl_q + HL_ONE;
					end else if (als_q && c == CH_SPACE) begin
						// drop spaces between hashes and title
					end else if (als_q) begin
						n_als = 1'b0;
						p_mask[SEG_BOLD_ON] = 1'b1;
						p_mask[SEG_HSPACE]  = (hl_q != HL_ONE);
						p_mask[SEG_CHAR]    = 1'b1;
						p_ch = (hl_q == HL_ONE) ? up : c;
					end else if (c == CH_NL) begin
						n_nlp = 1'b1;
					end else if (nlp_q) begin
						p_mask[SEG_HEND] = 1'b1;
						n_als    = 1'b1;
						n_nlp    = 1'b0;
						n_inws   = 1'b1;
						n_mode   = MODE_PLAIN;
						do_plain = 1'b1;
					end else begin
						p_mask[SEG_CHAR] = 1'b1;
						p_ch = (hl_q == HL_ONE) ? up : c;
					end
				end
				MODE_CODE: begin
					if (c == CH_TICK) begin
						n_mode = MODE_PLAIN;
						p_mask[SEG_BOLD_OFF] = 1'b1;
					end else begin
						do_para  = 1'b1;
						collapse = 1'b0;
					end
				end
				default: do_plain = 1'b1;
			endcase
		end

		if (do_plain) begin
			if (c == CH_HASH && n_als) begin
				n_mode = MODE_HEAD;
				n_inws = 1'b1;
				n_hl   = HL_ONE;
			end else if (c == CH_TICK) begin
				n_mode = MODE_CODE;
				p_mask[SEG_BOLD_ON] = 1'b1;
			end else begin
				do_para = 1'b1;
			end
		end

		if (do_para) begin
			if (n_als) begin
				p_mask[SEG_INDENT] = 1'b1;
				n_col = sat_add(n_col, 3'd4);
				n_als = 1'b0;
			end else if (n_col >= wrap_q) begin
				p_mask[SEG_WRAP] = 1'b1;
				n_col = 8'd4;
			end
			if (is_sp) begin
				if (!n_inws || !collapse) begin
					n_inws = 1'b1;
					p_mask[SEG_SPACE] = 1'b1;
					n_col = sat_add(n_col, 3'd1);
				end
				if (c == CH_NL) begin
					if (n_nlp) begin
						n_nlp = 1'b0;
						p_mask[SEG_DBLNL] = 1'b1;
						n_als = 1'b1;
						n_col = '0;
					end else begin
						n_nlp = 1'b1;
					end
				end
			end else begin
				n_nlp  = 1'b0;
				n_inws = 1'b0;
				p_mask[SEG_CHAR] = 1'b1;
				p_ch   = c;
				n_col  = sat_add(n_col, 3'd1);
			end
		end
	end

	// sequencer: current segment is the lowest pending one
	seg_t             cur;
	logic [IDX_W-1:0] last_idx;
	logic [NSEG-1:0]  rest;
	logic [7:0]       cur_byte;

	always_comb begin
		cur = SEG_RESET;
		for (int i = NSEG - 1; i >= 0; i--) begin
			if (mask_q[i]) cur = seg_t'(i);
		end
	end

	always_comb begin
		case (cur)
			SEG_HEND:     last_idx = IDX_W'(5);
			SEG_BOLD_ON:  last_idx = IDX_W'(3);
			SEG_HSPACE:   last_idx = IDX_W'(hl_q) - IDX_W'(2);
			SEG_INDENT:   last_idx = IDX_W'(3);
			SEG_WRAP:     last_idx = IDX_W'(4);
			SEG_SPACE:    last_idx = '0;
			SEG_CHAR:     last_idx = '0;
			SEG_DBLNL:    last_idx = IDX_W'(1);
			SEG_BOLD_OFF: last_idx = IDX_W'(4);
			SEG_RESET:    last_idx = IDX_W'(4);
			default:      last_idx = '0;
		endcase
	end

	always_comb begin
		rest = mask_q;
		rest[cur] = 1'b0;
	end

	always_comb begin
		cur_byte = CH_SPACE;
		case (cur)
			SEG_HEND: begin
				case (idx_q[2:0])
					3'd0:    cur_byte = CH_NL;
					3'd1:    cur_byte = CH_ESC;
					3'd2:    cur_byte = CH_LBRK;
					3'd3:    cur_byte = CH_TWO;
					3'd4:    cur_byte = CH_TWO;
					default: cur_byte = CH_M;
				endcase
			end
			SEG_BOLD_ON: begin
				case (idx_q[1:0])
					2'd0:    cur_byte = CH_ESC;
					2'd1:    cur_byte = CH_LBRK;
					2'd2:    cur_byte = CH_ONE;
					default: cur_byte = CH_M;
				endcase
			end
			SEG_WRAP:  cur_byte = (idx_q == '0) ? CH_NL : CH_SPACE;
			SEG_CHAR:  cur_byte = ch_q;
			SEG_DBLNL: cur_byte = CH_NL;
			SEG_BOLD_OFF: begin
				case (idx_q[2:0])
					3'd0:    cur_byte = CH_ESC;
					3'd1:    cur_byte = CH_LBRK;
					3'd2:    cur_byte = CH_TWO;
					3'd3:    cur_byte = CH_TWO;
					default: cur_byte = CH_M;
				endcase
			end
			SEG_RESET: begin
				case (idx_q[2:0])
					3'd0:    cur_byte = CH_ESC;
					3'd1:    cur_byte = CH_LBRK;
					3'd2:    cur_byte = CH_ZERO;
					3'd3:    cur_byte = CH_M;
					default: cur_byte = CH_NL;
				endcase
			end
			default: cur_byte = CH_SPACE;
		endcase
	end

	assign status.plan_any  = |p_mask;
	assign status.last_byte = (idx_q == last_idx) && (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			hl_q   <= '0;
			col_q  <= '0;
			als_q  <= 1'b1;
			nlp_q  <= 1'b0;
			inws_q <= 1'b1;
			wrap_q <= WRAP_RESET;
			mask_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.cfg_we) wrap_q <= cfg_data;
			if (cmd.accept) begin
				mode_q <= n_mode;
				hl_q   <= n_hl;
				col_q  <= n_col;
				als_q  <= n_als;
				nlp_q  <= n_nlp;
				inws_q <= n_inws;
				mask_q <= p_mask;
				idx_q  <= '0;
			end else if (cmd.step) begin
				// advance within the segment, or drop it and restart the index
				if (idx_q == last_idx) begin
					mask_q <= rest;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) ch_q <= p_ch;
		if (cmd.step) begin
			obyte_q <= cur_byte;
			olast_q <= status.last_byte;
		end
	end

	assign out_data.out_byte    = obyte_q;
	assign out_data.last_of_run = olast_q;

endmodule

### design/markdown_terminal_renderer_top.sv
// Top level of the markdown terminal renderer.
// Converts markdown bytes into ANSI terminal bytes, one input transaction at a time.
// An accepted transaction is decoded into a segment plan that yields up to 19 output
// bytes for a deep heading; a transaction that produces nothing does not leave idle.
// The single output register is loaded with one byte per cycle by the segment sequencer
// when it is empty or its byte is taken. While the last byte of a transaction waits
// in the output register the next input transaction is already taken. Paragraph text is
// indented four columns and wraps once the column reaches wrap_column (written through
// the cfg channel, reset 79; write it only while no transaction is in flight).
module markdown_terminal_renderer_top #(
	parameter int MAX_HEADING_LEVEL = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	// input transactions: one markdown byte or an end-of-text marker
	input  logic               in_valid,
	output logic               in_ready,
	input  mtr_pkg::in_item_t  in_data,
	// output transactions: terminal bytes, last_of_run on the final one of each input
	output logic               out_valid,
	input  logic               out_ready,
	output mtr_pkg::out_item_t out_data,
	// wrap column register write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import mtr_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	// Sequence decode, emit, and return to idle.
	mtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold render state, decode each byte into a segment plan, and walk it.
	mtr_dpath #(
		.MAX_HEADING_LEVEL (MAX_HEADING_LEVEL)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule
